// ===== rtl/mrsp_pkg.sv =====
// Shared types, constants and CRC helpers for the Modbus RTU sensor poller.
package mrsp_pkg;

   localparam int unsigned ADDR_W  = 5;
   localparam int unsigned REQ_LEN = 8;
   localparam int unsigned RSP_LEN = 11;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  FUNC_READ  = 8'h03;
   localparam logic [7:0]  BYTE_COUNT = 8'h06;
   localparam logic [15:0] START_REG  = 16'h0002;
   localparam logic [15:0] REG_COUNT  = 16'h0003;

   localparam logic        RST_ENABLE      = 1'b0;
   localparam logic [7:0]  RST_SLAVE_ADDR  = 8'd1;
   localparam logic [15:0] RST_POLL_PERIOD = 16'd1000;
   localparam logic [15:0] RST_TIMEOUT     = 16'd200;
   localparam logic [15:0] RST_MAX_DECIMAL = 16'd4;

   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_BYTE     = 2'd1,
      REQ_LINE_ERR = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_OK        = 3'd1,
      ST_TIMEOUT   = 3'd2,
      ST_LINE_ERR  = 3'd3,
      ST_FRAME_ERR = 3'd4,
      ST_CRC_ERR   = 3'd5
   } status_type;

   typedef enum logic {
      KIND_TX_BYTE = 1'b0,
      KIND_REPORT  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      REG_ENABLE      = 3'd0,
      REG_SLAVE_ADDR  = 3'd1,
      REG_POLL_PERIOD = 3'd2,
      REG_TIMEOUT     = 3'd3,
      REG_MAX_DECIMAL = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic        enable;
      logic [7:0]  node_addr;
      logic [15:0] poll_period_ms;
      logic [15:0] reply_timeout_ms;
      logic [15:0] max_decimal;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic        online;
      logic [15:0] unit_sel;
      logic [15:0] dec_places;
      logic [15:0] pressure;
      logic [31:0] good_total;
      logic [31:0] fail_total;
      logic [31:0] update_time;
   } stat_type;

   typedef struct packed {
      logic report;
      logic request;
   } start_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc_cur,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc_cur ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] req_byte(input logic [2:0]  idx,
                                           input logic [7:0]  addr,
                                           input logic [15:0] crc_cur);
      logic [7:0] r;
      unique case (idx)
         3'd0: r = addr;
         3'd1: r = FUNC_READ;
         3'd2: r = START_REG[15:8];
         3'd3: r = START_REG[7:0];
         3'd4: r = REG_COUNT[15:8];
         3'd5: r = REG_COUNT[7:0];
         3'd6: r = crc_cur[7:0];
         3'd7: r = crc_cur[15:8];
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/modbus_rtu_sensor_poller.sv =====
// Top level of the Modbus RTU sensor poller.
//
// Input channel (req_valid/req_stall): one request per millisecond tick,
// received serial byte or serial line error. Result channel (rsp_valid/
// rsp_stall): either a byte to transmit (rsp_kind 0, rsp_last on the eighth
// byte of a read request frame) or a status report with the stored readings.
// A request is processed at the edge that accepts it; its results are queued in
// the sequencer and pass from there through the output register to the channel.
// While the receiver does not stall, a request that yields one result or none
// is taken every cycle, and a tick that starts a poll yields eight request bytes
// (nine with a timeout report in front), one per cycle; the next request is taken
// in the cycle the last of them moves to the output register.
// When the receiver stalls, the output register holds its result. Requests
// that yield no result are still taken; the results of one more request wait
// in the sequencer, and then requests stall until those results drain.
// Reset clears all counters, the status and the readings and loads the
// configuration defaults: disabled, slave 1, period 1000 ticks, timeout
// 200 ticks, largest decimal point 4. Registers sit at byte addresses 4*i.
module modbus_rtu_sensor_poller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_type,
   input  logic [7:0]                   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic [7:0]                   rsp_tx_byte,
   output logic                         rsp_last,
   output logic [2:0]                   rsp_status,
   output logic                         rsp_online,
   output logic [15:0]                  rsp_unit_sel,
   output logic [15:0]                  rsp_dec_places,
   output logic signed [15:0]           rsp_pressure,
   output logic [31:0]                  rsp_good_total,
   output logic [31:0]                  rsp_fail_total,
   output logic [31:0]                  rsp_update_time,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [mrsp_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import mrsp_pkg::*;

   cfg_type   cfg;
   stat_type  stat;
   start_type start;
   logic      ready;
   logic      accept;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   mrsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mrsp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_type (req_type),
      .rx_byte  (req_rx_byte),
      .cfg      (cfg),
      .stat     (stat),
      .start    (start)
   );

   mrsp_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .start           (start),
      .stat            (stat),
      .node_addr       (cfg.node_addr),
      .ready           (ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_online      (rsp_online),
      .rsp_unit_sel    (rsp_unit_sel),
      .rsp_dec_places  (rsp_dec_places),
      .rsp_pressure    (rsp_pressure),
      .rsp_good_total  (rsp_good_total),
      .rsp_fail_total  (rsp_fail_total),
      .rsp_update_time (rsp_update_time)
   );

endmodule

// ===== rtl/mrsp_csr.sv =====
// APB-style configuration registers of the poller.
module mrsp_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mrsp_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output mrsp_pkg::cfg_type             cfg
);
   import mrsp_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_ENABLE:      cfg_in.enable           = csr_pwdata[0];
            REG_SLAVE_ADDR:  cfg_in.node_addr        = csr_pwdata[7:0];
            REG_POLL_PERIOD: cfg_in.poll_period_ms   = csr_pwdata[15:0];
            REG_TIMEOUT:     cfg_in.reply_timeout_ms = csr_pwdata[15:0];
            REG_MAX_DECIMAL: cfg_in.max_decimal      = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_ENABLE:      csr_prdata = {31'd0, cfg_ff.enable};
         REG_SLAVE_ADDR:  csr_prdata = {24'd0, cfg_ff.node_addr};
         REG_POLL_PERIOD: csr_prdata = {16'd0, cfg_ff.poll_period_ms};
         REG_TIMEOUT:     csr_prdata = {16'd0, cfg_ff.reply_timeout_ms};
         REG_MAX_DECIMAL: csr_prdata = {16'd0, cfg_ff.max_decimal};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable           <= RST_ENABLE;
         cfg_ff.node_addr        <= RST_SLAVE_ADDR;
         cfg_ff.poll_period_ms   <= RST_POLL_PERIOD;
         cfg_ff.reply_timeout_ms <= RST_TIMEOUT;
         cfg_ff.max_decimal      <= RST_MAX_DECIMAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/mrsp_core.sv =====
// Poll timing, reply capture, reply checks and stored status of the poller.
module mrsp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           req_type,
   input  logic [7:0]           rx_byte,
   input  mrsp_pkg::cfg_type    cfg,
   output mrsp_pkg::stat_type   stat,
   output mrsp_pkg::start_type  start
);
   import mrsp_pkg::*;

   localparam int unsigned STORE_LEN = RSP_LEN - 1;
   localparam int unsigned CRC_LEN   = RSP_LEN - 2;

   logic [15:0] poll_count_ff, poll_count_in;
   logic [15:0] wait_count_ff, wait_count_in;
   logic        waiting_ff, waiting_in;
   logic [3:0]  rx_index_ff, rx_index_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [31:0] time_now_ff, time_now_in;
   stat_type    stat_ff, stat_in;
   logic [7:0]  rx_bytes_ff [STORE_LEN];
   logic        rx_wr_en;
   logic [15:0] poll_next;
   logic [15:0] wait_next;
   logic        header_ok;
   logic        crc_ok;
   logic [15:0] dec_value;

   assign poll_next = (poll_count_ff == 16'hFFFF) ? poll_count_ff : poll_count_ff + 16'd1;
   assign wait_next = (wait_count_ff == 16'hFFFF) ? wait_count_ff : wait_count_ff + 16'd1;
   assign header_ok = (rx_bytes_ff[0] == cfg.node_addr) && (rx_bytes_ff[1] == FUNC_READ)
                      && (rx_bytes_ff[2] == BYTE_COUNT);
   assign crc_ok    = (rx_bytes_ff[9] == rx_crc_ff[7:0]) && (rx_byte == rx_crc_ff[15:8]);
   assign dec_value = {rx_bytes_ff[5], rx_bytes_ff[6]};
   assign stat      = stat_ff;

   always_comb begin
      poll_count_in = poll_count_ff;
      wait_count_in = wait_count_ff;
      waiting_in    = waiting_ff;
      rx_index_in   = rx_index_ff;
      rx_crc_in     = rx_crc_ff;
      time_now_in   = time_now_ff;
      stat_in       = stat_ff;
      rx_wr_en      = 1'b0;
      start         = '0;
      if (accept) begin
         unique case (req_kind_type'(req_type))
            REQ_TICK: begin
               time_now_in   = time_now_ff + 32'd1;
               poll_count_in = poll_next;
               if (waiting_ff) begin
                  wait_count_in = wait_next;
                  if (wait_next >= cfg.reply_timeout_ms) begin
                     waiting_in         = 1'b0;
                     stat_in.status     = ST_TIMEOUT;
                     stat_in.online     = 1'b0;
                     stat_in.fail_total = stat_ff.fail_total + 32'd1;
                     start.report       = 1'b1;
                  end
               end
               if (!waiting_in && cfg.enable && (poll_next >= cfg.poll_period_ms)) begin
                  poll_count_in = 16'd0;
                  waiting_in    = 1'b1;
                  wait_count_in = 16'd0;
                  rx_index_in   = 4'd0;
                  rx_crc_in     = CRC_INIT;
                  start.request = 1'b1;
               end
            end
            REQ_BYTE: begin
               if (waiting_ff && (rx_index_ff < 4'(RSP_LEN))) begin
                  rx_wr_en    = (rx_index_ff < 4'(STORE_LEN));
                  rx_index_in = rx_index_ff + 4'd1;
                  if (rx_index_ff < 4'(CRC_LEN)) begin
                     rx_crc_in = crc_update(rx_crc_ff, rx_byte);
                  end
                  if (rx_index_ff == 4'(RSP_LEN - 1)) begin
                     waiting_in   = 1'b0;
                     rx_index_in  = 4'd0;
                     start.report = 1'b1;
                     if (!header_ok) begin
                        stat_in.status     = ST_FRAME_ERR;
                        stat_in.online     = 1'b0;
                        stat_in.fail_total = stat_ff.fail_total + 32'd1;
                     end else if (!crc_ok) begin
                        stat_in.status     = ST_CRC_ERR;
                        stat_in.online     = 1'b0;
                        stat_in.fail_total = stat_ff.fail_total + 32'd1;
                     end else begin
                        stat_in.unit_sel    = {rx_bytes_ff[3], rx_bytes_ff[4]};
                        stat_in.dec_places  = dec_value;
                        stat_in.pressure    = {rx_bytes_ff[7], rx_bytes_ff[8]};
                        stat_in.update_time = time_now_ff;
                        stat_in.good_total  = stat_ff.good_total + 32'd1;
                        if (dec_value > cfg.max_decimal) begin
                           stat_in.status     = ST_FRAME_ERR;
                           stat_in.online     = 1'b0;
                           stat_in.fail_total = stat_ff.fail_total + 32'd1;
                        end else begin
                           stat_in.status = ST_OK;
                           stat_in.online = 1'b1;
                        end
                     end
                  end
               end
            end
            REQ_LINE_ERR: begin
               if (waiting_ff) begin
                  waiting_in         = 1'b0;
                  rx_index_in        = 4'd0;
                  stat_in.status     = ST_LINE_ERR;
                  stat_in.online     = 1'b0;
                  stat_in.fail_total = stat_ff.fail_total + 32'd1;
                  start.report       = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rx_wr_en) begin
         rx_bytes_ff[rx_index_ff] <= rx_byte;
      end
      rx_crc_ff <= rx_crc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_count_ff <= 16'd0;
         wait_count_ff <= 16'd0;
         waiting_ff    <= 1'b0;
         rx_index_ff   <= 4'd0;
         time_now_ff   <= 32'd0;
         stat_ff       <= '{status: ST_IDLE, default: '0};
      end else begin
         poll_count_ff <= poll_count_in;
         wait_count_ff <= wait_count_in;
         waiting_ff    <= waiting_in;
         rx_index_ff   <= rx_index_in;
         time_now_ff   <= time_now_in;
         stat_ff       <= stat_in;
      end
   end

endmodule

// ===== rtl/mrsp_emit.sv =====
// Result sequencer: pending report and request bytes feeding the output register.
module mrsp_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  mrsp_pkg::start_type  start,
   input  mrsp_pkg::stat_type   stat,
   input  logic [7:0]           node_addr,
   output logic                 ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_kind,
   output logic [7:0]           rsp_tx_byte,
   output logic                 rsp_last,
   output logic [2:0]           rsp_status,
   output logic                 rsp_online,
   output logic [15:0]          rsp_unit_sel,
   output logic [15:0]          rsp_dec_places,
   output logic signed [15:0]   rsp_pressure,
   output logic [31:0]          rsp_good_total,
   output logic [31:0]          rsp_fail_total,
   output logic [31:0]          rsp_update_time
);
   import mrsp_pkg::*;

   localparam int unsigned CRC_BYTES = REQ_LEN - 2;

   logic        pend_rep_ff, pend_rep_in;
   logic [3:0]  req_left_ff, req_left_in;
   logic [15:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  tx_ff, tx_in;
   logic        last_ff, last_in;
   stat_type    stat_out_ff, stat_out_in;
   logic        have;
   logic        take_out;
   logic        drain;
   logic        one_left;
   logic [3:0]  byte_idx;
   logic [7:0]  cur_byte;

   assign have     = pend_rep_ff || (req_left_ff != 4'd0);
   assign take_out = !out_valid_ff || !rsp_stall;
   assign drain    = have && take_out;
   assign one_left = (pend_rep_ff && (req_left_ff == 4'd0))
                     || (!pend_rep_ff && (req_left_ff == 4'd1));
   assign ready    = !have || (one_left && drain);
   assign byte_idx = 4'(REQ_LEN) - req_left_ff;
   assign cur_byte = req_byte(byte_idx[2:0], node_addr, crc_ff);

   always_comb begin
      pend_rep_in  = pend_rep_ff;
      req_left_in  = req_left_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      tx_in        = tx_ff;
      last_in      = last_ff;
      stat_out_in  = stat_out_ff;
      if (drain) begin
         out_valid_in = 1'b1;
         if (pend_rep_ff) begin
            pend_rep_in = 1'b0;
            kind_in     = KIND_REPORT;
            tx_in       = 8'd0;
            last_in     = 1'b0;
            stat_out_in = stat;
         end else begin
            req_left_in = req_left_ff - 4'd1;
            kind_in     = KIND_TX_BYTE;
            tx_in       = cur_byte;
            last_in     = (byte_idx == 4'(REQ_LEN - 1));
            stat_out_in = '{status: ST_IDLE, default: '0};
            if (byte_idx < 4'(CRC_BYTES)) begin
               crc_in = crc_update(crc_ff, cur_byte);
            end
         end
      end else if (take_out) begin
         out_valid_in = 1'b0;
      end
      if (accept) begin
         pend_rep_in = start.report;
         req_left_in = start.request ? 4'(REQ_LEN) : 4'd0;
         crc_in      = CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      tx_ff       <= tx_in;
      last_ff     <= last_in;
      stat_out_ff <= stat_out_in;
      crc_ff      <= crc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_rep_ff  <= 1'b0;
         req_left_ff  <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_rep_ff  <= pend_rep_in;
         req_left_ff  <= req_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_tx_byte     = tx_ff;
   assign rsp_last        = last_ff;
   assign rsp_status      = stat_out_ff.status;
   assign rsp_online      = stat_out_ff.online;
   assign rsp_unit_sel    = stat_out_ff.unit_sel;
   assign rsp_dec_places  = stat_out_ff.dec_places;
   assign rsp_pressure    = signed'(stat_out_ff.pressure);
   assign rsp_good_total  = stat_out_ff.good_total;
   assign rsp_fail_total  = stat_out_ff.fail_total;
   assign rsp_update_time = stat_out_ff.update_time;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the Modbus RTU sensor poller: scripted and random polls.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mrsp_pkg::*;

   localparam int         CLK_PERIOD    = 20;
   localparam int         STALL_LIMIT   = 4000;
   localparam int         SETTLE_CYCLES = 12;
   localparam logic [1:0] REQ_UNUSED    = 2'd3;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] tx_byte;
      logic       last;
      stat_type   st;
   } poller_out_type;

   typedef enum logic [1:0] {
      ROW_REQ,
      ROW_CFG,
      ROW_CRC_LO,
      ROW_CRC_HI
   } row_kind_type;

   typedef struct packed {
      row_kind_type  what;
      logic [1:0]    rtype;
      logic [7:0]    data;
      reg_index_type reg_sel;
      logic [31:0]   reg_val;
      logic          chk;
      status_type    want;
   } script_row_type;

   localparam script_row_type SCRIPT [36] = '{
      '{ROW_REQ, REQ_BYTE,     8'hFF, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_LINE_ERR, 8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_UNUSED,   8'h5A, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_TICK,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_ENABLE,      32'd1,     1'b0, ST_IDLE},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_SLAVE_ADDR,  32'hFF,    1'b0, ST_IDLE},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_POLL_PERIOD, 32'd0,     1'b0, ST_IDLE},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_TIMEOUT,     32'd0,     1'b0, ST_IDLE},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_MAX_DECIMAL, 32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_TICK,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_TICK,     8'hFF, REG_ENABLE,      32'd0,     1'b1, ST_TIMEOUT},
      '{ROW_REQ, REQ_LINE_ERR, 8'hFF, REG_ENABLE,      32'd0,     1'b1, ST_LINE_ERR},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_POLL_PERIOD, 32'd1,     1'b0, ST_IDLE},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_TIMEOUT,     32'hFFFF,  1'b0, ST_IDLE},
      '{ROW_REQ, REQ_TICK,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_SLAVE_ADDR,  32'h00,    1'b0, ST_IDLE},
      '{ROW_REQ, REQ_BYTE,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_BYTE,     8'h03, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_BYTE,     8'h06, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_BYTE,     8'hFF, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_BYTE,     8'hFF, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_BYTE,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_BYTE,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_BYTE,     8'h80, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_BYTE,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_CRC_LO, REQ_BYTE,  8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_CRC_HI, REQ_BYTE,  8'h00, REG_ENABLE,      32'd0,     1'b1, ST_OK},
      '{ROW_REQ, REQ_TICK,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_ENABLE,      32'd1,     1'b0, ST_IDLE},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_MAX_DECIMAL, 32'hFFFF,  1'b0, ST_IDLE},
      '{ROW_REQ, REQ_TICK,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_BYTE,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE},
      '{ROW_REQ, REQ_LINE_ERR, 8'h00, REG_ENABLE,      32'd0,     1'b1, ST_LINE_ERR},
      '{ROW_CFG, REQ_TICK,     8'h00, REG_POLL_PERIOD, 32'hFFFF,  1'b0, ST_IDLE},
      '{ROW_REQ, REQ_TICK,     8'h00, REG_ENABLE,      32'd0,     1'b0, ST_IDLE}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_type = REQ_TICK;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_kind;
   logic [7:0]           rsp_tx_byte;
   logic                 rsp_last;
   logic [2:0]           rsp_status;
   logic                 rsp_online;
   logic [15:0]          rsp_unit_sel;
   logic [15:0]          rsp_dec_places;
   logic signed [15:0]   rsp_pressure;
   logic [31:0]          rsp_good_total;
   logic [31:0]          rsp_fail_total;
   logic [31:0]          rsp_update_time;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]    csr_paddr = '0;
   logic [31:0]          csr_pwdata = '0;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   cfg_type              cfg_now;
   stat_type             stat_now;
   logic [15:0]          poll_cnt;
   logic [15:0]          wait_cnt;
   logic                 awaiting;
   int unsigned          rx_idx;
   logic [7:0]           rx_buf [RSP_LEN];
   logic [31:0]          tick_now;
   poller_out_type       due_results [$];
   poller_out_type       oldest;

   int                   send_idle_pct = 0;
   int                   rsp_idle_pct = 0;
   int                   mismatches = 0;
   int                   quiet_cycles = 0;
   int                   accepted = 0;
   int                   frames_sent = 0;
   int                   reports_made = 0;
   int unsigned          status_seen [8];

   modbus_rtu_sensor_poller u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_online      (rsp_online),
      .rsp_unit_sel    (rsp_unit_sel),
      .rsp_dec_places  (rsp_dec_places),
      .rsp_pressure    (rsp_pressure),
      .rsp_good_total  (rsp_good_total),
      .rsp_fail_total  (rsp_fail_total),
      .rsp_update_time (rsp_update_time),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   function automatic logic [15:0] modbus_crc(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic logic [15:0] reply_crc();
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < 9; i++) c = modbus_crc(c, rx_buf[i]);
      return c;
   endfunction

   function automatic void push_report();
      poller_out_type r;
      r = '0;
      r.kind = KIND_REPORT;
      r.st = stat_now;
      due_results.push_back(r);
      status_seen[stat_now.status]++;
      reports_made++;
   endfunction

   function automatic void mark_failed(input status_type s);
      stat_now.status = s;
      stat_now.online = 1'b0;
      stat_now.fail_total++;
   endfunction

   function automatic int advance_poller(input logic [1:0] t, input logic [7:0] b);
      int             n;
      logic [15:0]    crc;
      logic [7:0]     frame [REQ_LEN];
      poller_out_type r;
      n = due_results.size();
      accepted++;
      unique case (t)
         REQ_TICK: begin
            tick_now++;
            if (poll_cnt != 16'hFFFF) poll_cnt++;
            if (awaiting) begin
               if (wait_cnt != 16'hFFFF) wait_cnt++;
               if (wait_cnt >= cfg_now.reply_timeout_ms) begin
                  awaiting = 1'b0;
                  mark_failed(ST_TIMEOUT);
                  push_report();
               end
            end
            if (!awaiting && cfg_now.enable && poll_cnt >= cfg_now.poll_period_ms) begin
               frame = '{cfg_now.node_addr, FUNC_READ, START_REG[15:8], START_REG[7:0],
                         REG_COUNT[15:8], REG_COUNT[7:0], 8'h00, 8'h00};
               crc = CRC_INIT;
               for (int i = 0; i < 6; i++) crc = modbus_crc(crc, frame[i]);
               frame[6] = crc[7:0];
               frame[7] = crc[15:8];
               for (int i = 0; i < REQ_LEN; i++) begin
                  r = '0;
                  r.kind = KIND_TX_BYTE;
                  r.tx_byte = frame[i];
                  r.last = (i == REQ_LEN - 1);
                  due_results.push_back(r);
               end
               poll_cnt = '0;
               wait_cnt = '0;
               rx_idx = 0;
               awaiting = 1'b1;
               frames_sent++;
            end
         end
         REQ_BYTE: begin
            if (awaiting && rx_idx < RSP_LEN) begin
               rx_buf[rx_idx] = b;
               rx_idx++;
               if (rx_idx == RSP_LEN) begin
                  awaiting = 1'b0;
                  rx_idx = 0;
                  crc = reply_crc();
                  if (rx_buf[0] != cfg_now.node_addr || rx_buf[1] != FUNC_READ ||
                      rx_buf[2] != BYTE_COUNT) begin
                     mark_failed(ST_FRAME_ERR);
                  end else if (rx_buf[9] != crc[7:0] || rx_buf[10] != crc[15:8]) begin
                     mark_failed(ST_CRC_ERR);
                  end else begin
                     stat_now.unit_sel = {rx_buf[3], rx_buf[4]};
                     stat_now.dec_places = {rx_buf[5], rx_buf[6]};
                     stat_now.pressure = {rx_buf[7], rx_buf[8]};
                     stat_now.online = 1'b1;
                     stat_now.status = ST_OK;
                     stat_now.update_time = tick_now;
                     stat_now.good_total++;
                     if (stat_now.dec_places > cfg_now.max_decimal) begin
                        mark_failed(ST_FRAME_ERR);
                     end
                  end
                  push_report();
               end
            end
         end
         REQ_LINE_ERR: begin
            if (awaiting) begin
               awaiting = 1'b0;
               rx_idx = 0;
               mark_failed(ST_LINE_ERR);
               push_report();
            end
         end
         default: ;
      endcase
      return due_results.size() - n;
   endfunction

   function automatic logic [7:0] reply_byte();
      logic [7:0]  v;
      logic [7:0]  rnd;
      logic [15:0] crc;
      int unsigned roll;
      roll = $urandom_range(99);
      rnd = 8'($urandom);
      unique case (rx_idx)
         0:  v = (roll < 5) ? rnd : cfg_now.node_addr;
         1:  v = (roll < 5) ? rnd : FUNC_READ;
         2:  v = (roll < 4) ? rnd : BYTE_COUNT;
         5:  v = (roll < 70) ? 8'h00 : rnd;
         6:  v = (roll < 70) ? 8'($urandom_range(0, 12)) : rnd;
         9: begin
            crc = reply_crc();
            v = crc[7:0] ^ ((roll < 6) ? (8'd1 << roll) : 8'h00);
         end
         10: begin
            crc = reply_crc();
            v = crc[15:8] ^ ((roll < 4) ? 8'h80 : 8'h00);
         end
         default: v = rnd;
      endcase
      return v;
   endfunction

   function automatic void cmp_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_req(input logic [1:0] t, input logic [7:0] b, output int n);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_type <= t;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      n = advance_poller(t, b);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input reg_index_type r, input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      unique case (r)
         REG_ENABLE:      cfg_now.enable = v[0];
         REG_SLAVE_ADDR:  cfg_now.node_addr = v[7:0];
         REG_POLL_PERIOD: cfg_now.poll_period_ms = v[15:0];
         REG_TIMEOUT:     cfg_now.reply_timeout_ms = v[15:0];
         REG_MAX_DECIMAL: cfg_now.max_decimal = v[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic run_phase(input int s_idle, input int r_idle, input logic [7:0] addr,
                            input logic [15:0] period, input logic [15:0] tmo,
                            input logic [15:0] max_dec, input int target);
      int          counted;
      int          n;
      int unsigned roll;
      counted = 0;
      settle();
      send_idle_pct = s_idle;
      rsp_idle_pct = r_idle;
      csr_put(REG_ENABLE, 32'd1);
      csr_put(REG_SLAVE_ADDR, {24'h0, addr});
      csr_put(REG_POLL_PERIOD, {16'h0, period});
      csr_put(REG_TIMEOUT, {16'h0, tmo});
      csr_put(REG_MAX_DECIMAL, {16'h0, max_dec});
      while (counted < target) begin
         // now and then hold until the result channel drains
         if ($urandom_range(99) < 2) settle();
         roll = $urandom_range(99);
         if (!awaiting) begin
            if (roll < 3) begin
               send_req(REQ_BYTE, 8'($urandom), n);
            end else if (roll < 5) begin
               send_req(REQ_LINE_ERR, 8'($urandom), n);
            end else if (roll < 6) begin
               send_req(REQ_UNUSED, 8'($urandom), n);
            end else begin
               send_req(REQ_TICK, 8'($urandom), n);
               counted++;
            end
         end else begin
            if (roll < 4) begin
               send_req(REQ_LINE_ERR, 8'($urandom), n);
               counted++;
            end else if (roll < 12) begin
               send_req(REQ_TICK, 8'($urandom), n);
               counted++;
            end else if (roll < 14) begin
               send_req(REQ_UNUSED, 8'($urandom), n);
            end else begin
               send_req(REQ_BYTE, reply_byte(), n);
               counted++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("result with nothing pending, kind %0d", rsp_kind);
               mismatches++;
            end else begin
               oldest = due_results.pop_front();
               cmp_field("kind", 32'(oldest.kind), 32'(rsp_kind));
               cmp_field("tx_byte", 32'(oldest.tx_byte), 32'(rsp_tx_byte));
               cmp_field("last", 32'(oldest.last), 32'(rsp_last));
               cmp_field("status", 32'(oldest.st.status), 32'(rsp_status));
               cmp_field("online", 32'(oldest.st.online), 32'(rsp_online));
               cmp_field("unit_sel", 32'(oldest.st.unit_sel), 32'(rsp_unit_sel));
               cmp_field("dec_places", 32'(oldest.st.dec_places), 32'(rsp_dec_places));
               cmp_field("pressure", 32'(oldest.st.pressure), 32'($unsigned(rsp_pressure)));
               cmp_field("good_total", oldest.st.good_total, rsp_good_total);
               cmp_field("fail_total", oldest.st.fail_total, rsp_fail_total);
               cmp_field("update_time", oldest.st.update_time, rsp_update_time);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   initial begin
      script_row_type row;
      poller_out_type r;
      logic [15:0]    crc;
      int             n;
      cfg_now = '{RST_ENABLE, RST_SLAVE_ADDR, RST_POLL_PERIOD, RST_TIMEOUT, RST_MAX_DECIMAL};
      stat_now = '0;
      poll_cnt = '0;
      wait_cnt = '0;
      awaiting = 1'b0;
      rx_idx = 0;
      tick_now = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      rsp_idle_pct = 69;
      foreach (SCRIPT[i]) begin
         row = SCRIPT[i];
         n = 0;
         unique case (row.what)
            ROW_CFG: begin
               settle();
               csr_put(row.reg_sel, row.reg_val);
            end
            ROW_CRC_LO: begin
               crc = reply_crc();
               send_req(REQ_BYTE, crc[7:0], n);
            end
            ROW_CRC_HI: begin
               crc = reply_crc();
               send_req(REQ_BYTE, crc[15:8], n);
            end
            default: send_req(row.rtype, row.data, n);
         endcase
         if (row.chk) begin
            if (n == 0) begin
               $error("script row %0d: status expected %0d, no report", i, row.want);
               mismatches++;
            end else begin
               r = due_results[due_results.size() - n];
               r.st.status = row.want;
               due_results[due_results.size() - n] = r;
            end
         end
      end

      run_phase(29, 69, 8'($urandom_range(1, 254)), 16'($urandom_range(1, 4)),
                16'($urandom_range(6, 20)), 16'($urandom_range(0, 8)), 50);
      run_phase(69, 29, 8'hFF, 16'($urandom_range(0, 2)), 16'($urandom_range(1, 4)),
                16'($urandom_range(0, 8)), 50);
      run_phase(0, 0, 8'h00, 16'($urandom_range(1, 3)), 16'($urandom_range(10, 40)),
                16'($urandom_range(0, 8)), 40);
      settle();

      $display("summary: %0d requests taken, %0d poll frames, %0d status reports",
               accepted, frames_sent, reports_made);
      $display("summary: ok %0d, timeout %0d, line error %0d, frame error %0d, crc error %0d",
               status_seen[ST_OK], status_seen[ST_TIMEOUT], status_seen[ST_LINE_ERR],
               status_seen[ST_FRAME_ERR], status_seen[ST_CRC_ERR]);
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mrsp_pkg.sv
rtl/mrsp_csr.sv
rtl/mrsp_core.sv
rtl/mrsp_emit.sv
rtl/modbus_rtu_sensor_poller.sv
verif/tb.sv
